### rtl/eebe_pkg.sv
// shared types, constants and arithmetic helpers for the edge basis evaluator
`timescale 1ns / 1ps
package eebe_pkg;

  // element and result shape
  localparam int DOF_COUNT   = 4;
  localparam int DOF_W       = 2;
  localparam int COMP_COUNT  = 3;
  localparam int COMP_W      = 2;
  localparam int FRAC_BITS   = 12;

  // operand widths
  localparam int COORD_W     = 18;
  localparam int TERM_W      = 19;
  localparam int ELEM_W      = 20;
  localparam int VEC_W       = 3 * ELEM_W;
  localparam int OUT_W       = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int ONE_Q16     = 65536;

  // rounding positions: bilinear weight carries 32 fraction bits, derivatives 16; shifts 35 and 19
  localparam int FIELD_SHIFT = 35;
  localparam int CURL_SHIFT  = 19;
  localparam int GRAD_SHIFT  = FRAC_BITS + 19;

  // point queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGNS     = 3'd0,
    REG_TANGENT   = 3'd1,
    REG_BINORMAL  = 3'd2,
    REG_NORMAL    = 3'd3,
    REG_CURL_ETA  = 3'd4,
    REG_CURL_ZETA = 3'd5
  } reg_idx_t;

  // element frame as held in configuration
  typedef struct packed {
    logic [DOF_COUNT-1:0] signs;
    logic [VEC_W-1:0]     tangent;
    logic [VEC_W-1:0]     binormal;
    logic [VEC_W-1:0]     normal;
    logic [VEC_W-1:0]     curl_eta;
    logic [VEC_W-1:0]     curl_zeta;
  } cfg_t;

  // per-point factor terms 1 -/+ eta and 1 -/+ zeta in Q16
  typedef struct packed {
    logic signed [TERM_W-1:0] fe_m;
    logic signed [TERM_W-1:0] fe_p;
    logic signed [TERM_W-1:0] fz_m;
    logic signed [TERM_W-1:0] fz_p;
  } terms_t;

  // one signed component of a packed vector register
  function automatic logic signed [ELEM_W-1:0] vec_elem(input logic [VEC_W-1:0] vec,
                                                        input logic [COMP_W-1:0] idx);
    logic signed [ELEM_W-1:0] e;
    case (idx)
      2'd0:    e = vec[ELEM_W-1:0];
      2'd1:    e = vec[2*ELEM_W-1:ELEM_W];
      2'd2:    e = vec[3*ELEM_W-1:2*ELEM_W];
      default: e = '0;
    endcase
    return e;
  endfunction

  // round to nearest with ties upward, then saturate to 32 bits
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [63:0] v,
                                                        input int unsigned s);
    logic signed [63:0] t;
    t = (v + (64'sd1 <<< (s - 1))) >>> s;
    if (t > 64'sd2147483647) begin
      t = 64'sd2147483647;
    end else if (t < -64'sd2147483648) begin
      t = -64'sd2147483648;
    end
    return OUT_W'(t);
  endfunction

endpackage

### rtl/edge_element_basis_eval.sv
// top level: configuration registers, point front end and result back end
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+---------------------------------------------
//  point    | start / busy              | eta, zeta
//  result   | result_valid (strobe)     | dof_index, component, field_value, curl_value,
//           |                           | grad_x, grad_y, grad_z, last
//  config   | cfg_write                 | cfg_index, cfg_data
//
// each point yields twelve result beats, one per cycle, all from the single shared
// evaluation pipeline
// the first result passes through the queue, stages 0 to 3 and the output register
// a two-entry point queue lets the next point in while the current one is evaluated
// rst is synchronous and clears the registers, the queue and the pipeline valids
// results cannot be held off, so the pipeline never stalls
`timescale 1ns / 1ps
module edge_element_basis_eval (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [eebe_pkg::COORD_W-1:0]   eta,
  input  logic signed [eebe_pkg::COORD_W-1:0]   zeta,
  input  logic                                  cfg_write,
  input  logic [eebe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [eebe_pkg::VEC_W-1:0]            cfg_data,
  output logic                                  result_valid,
  output logic [eebe_pkg::DOF_W-1:0]            dof_index,
  output logic [eebe_pkg::COMP_W-1:0]           component,
  output logic signed [eebe_pkg::OUT_W-1:0]     field_value,
  output logic signed [eebe_pkg::OUT_W-1:0]     curl_value,
  output logic signed [eebe_pkg::OUT_W-1:0]     grad_x,
  output logic signed [eebe_pkg::OUT_W-1:0]     grad_y,
  output logic signed [eebe_pkg::OUT_W-1:0]     grad_z,
  output logic                                  last
);

  eebe_pkg::cfg_t    cfg;
  eebe_pkg::terms_t  q_head;
  logic              q_valid;
  logic              pop;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (eebe_pkg::reg_idx_t'(cfg_index))
        eebe_pkg::REG_SIGNS:     cfg.signs     <= cfg_data[eebe_pkg::DOF_COUNT-1:0];
        eebe_pkg::REG_TANGENT:   cfg.tangent   <= cfg_data;
        eebe_pkg::REG_BINORMAL:  cfg.binormal  <= cfg_data;
        eebe_pkg::REG_NORMAL:    cfg.normal    <= cfg_data;
        eebe_pkg::REG_CURL_ETA:  cfg.curl_eta  <= cfg_data;
        eebe_pkg::REG_CURL_ZETA: cfg.curl_zeta <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // point intake and queue
  eebe_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .eta     (eta),
    .zeta    (zeta),
    .q_valid (q_valid),
    .q_head  (q_head),
    .pop     (pop)
  );

  // result evaluation
  eebe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .result_valid (result_valid),
    .dof_index    (dof_index),
    .component    (component),
    .field_value  (field_value),
    .curl_value   (curl_value),
    .grad_x       (grad_x),
    .grad_y       (grad_y),
    .grad_z       (grad_z),
    .last         (last)
  );

endmodule

### rtl/eebe_front.sv
// front end: takes a point beat, forms its factor terms and queues them
`timescale 1ns / 1ps
module eebe_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [eebe_pkg::COORD_W-1:0]   eta,
  input  logic signed [eebe_pkg::COORD_W-1:0]   zeta,
  output logic                                  q_valid,
  output eebe_pkg::terms_t                      q_head,
  input  logic                                  pop
);

  localparam logic signed [eebe_pkg::TERM_W-1:0] ONE = eebe_pkg::TERM_W'(eebe_pkg::ONE_Q16);

  eebe_pkg::terms_t             entry [eebe_pkg::QUEUE_DEPTH];
  eebe_pkg::terms_t             terms;
  logic [eebe_pkg::QPTR_W-1:0]  wr_ptr;
  logic [eebe_pkg::QPTR_W-1:0]  rd_ptr;
  logic [eebe_pkg::QCNT_W-1:0]  count;
  logic                         push;

  // factor terms of the incoming point
  always_comb begin
    terms.fe_m = ONE - eebe_pkg::TERM_W'(eta);
    terms.fe_p = ONE + eebe_pkg::TERM_W'(eta);
    terms.fz_m = ONE - eebe_pkg::TERM_W'(zeta);
    terms.fz_p = ONE + eebe_pkg::TERM_W'(zeta);
  end

  // accept while the queue has room
  assign busy    = (count == eebe_pkg::QCNT_W'(eebe_pkg::QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (count != '0);
  assign q_head  = entry[rd_ptr];

  // queue control
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= terms;
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("point queue popped while empty");

endmodule

### rtl/eebe_back.sv
// back end: steps through dofs and components and evaluates each result
`timescale 1ns / 1ps
module eebe_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  eebe_pkg::cfg_t                        cfg,
  input  logic                                  q_valid,
  input  eebe_pkg::terms_t                      q_head,
  output logic                                  pop,
  output logic                                  result_valid,
  output logic [eebe_pkg::DOF_W-1:0]            dof_index,
  output logic [eebe_pkg::COMP_W-1:0]           component,
  output logic signed [eebe_pkg::OUT_W-1:0]     field_value,
  output logic signed [eebe_pkg::OUT_W-1:0]     curl_value,
  output logic signed [eebe_pkg::OUT_W-1:0]     grad_x,
  output logic signed [eebe_pkg::OUT_W-1:0]     grad_y,
  output logic signed [eebe_pkg::OUT_W-1:0]     grad_z,
  output logic                                  last
);

  localparam int TW = eebe_pkg::TERM_W;
  localparam int EW = eebe_pkg::ELEM_W;
  localparam int AW = EW + 1;            // signed tangent component
  localparam int FW = 2 * TW;            // bilinear weight
  localparam int PW = TW + EW;           // derivative times vector component
  localparam int SW = PW + 1;            // sum of two such products
  localparam int CW = SW + 1;            // signed curl
  localparam int XW = FW + AW;           // field product
  localparam int GW = SW + AW;           // gradient product
  localparam logic [eebe_pkg::DOF_W-1:0]  K_LAST = eebe_pkg::DOF_W'(eebe_pkg::DOF_COUNT - 1);
  localparam logic [eebe_pkg::COMP_W-1:0] J_LAST = eebe_pkg::COMP_W'(eebe_pkg::COMP_COUNT - 1);

  // sequencer
  logic [eebe_pkg::DOF_W-1:0]  k_cnt;
  logic [eebe_pkg::COMP_W-1:0] j_cnt;
  logic                        end_pt;

  // stage 0
  logic                        s0_valid, s0_last, s0_neg;
  logic [eebe_pkg::DOF_W-1:0]  s0_k;
  logic [eebe_pkg::COMP_W-1:0] s0_j;
  logic signed [TW-1:0]        s0_fe, s0_fz, s0_deta, s0_dzeta;
  logic signed [AW-1:0]        s0_saj;
  logic signed [EW-1:0]        s0_pj, s0_qj;

  // stage 1
  logic                        s1_valid, s1_last, s1_neg;
  logic [eebe_pkg::DOF_W-1:0]  s1_k;
  logic [eebe_pkg::COMP_W-1:0] s1_j;
  logic signed [AW-1:0]        s1_saj;
  logic signed [FW-1:0]        s1_fnum;
  logic signed [PW-1:0]        s1_cp, s1_cq;
  logic signed [PW-1:0]        s1_gb [eebe_pkg::COMP_COUNT];
  logic signed [PW-1:0]        s1_gn [eebe_pkg::COMP_COUNT];

  // stage 2
  logic                        s2_valid, s2_last;
  logic [eebe_pkg::DOF_W-1:0]  s2_k;
  logic [eebe_pkg::COMP_W-1:0] s2_j;
  logic signed [AW-1:0]        s2_saj;
  logic signed [XW-1:0]        s2_field;
  logic signed [CW-1:0]        s2_curl;
  logic signed [SW-1:0]        s2_g [eebe_pkg::COMP_COUNT];

  // stage 3
  logic                        s3_valid, s3_last;
  logic [eebe_pkg::DOF_W-1:0]  s3_k;
  logic [eebe_pkg::COMP_W-1:0] s3_j;
  logic signed [eebe_pkg::OUT_W-1:0] s3_field, s3_curl;
  logic signed [GW-1:0]        s3_grad [eebe_pkg::COMP_COUNT];

  // stage 0 operand selection
  logic signed [TW-1:0]        fe_sel, fz_sel;
  logic signed [EW-1:0]        aj;

  assign end_pt = (k_cnt == K_LAST) && (j_cnt == J_LAST);
  assign pop    = q_valid && end_pt;

  always_comb begin
    fe_sel = k_cnt[0] ? q_head.fe_p : q_head.fe_m;
    fz_sel = k_cnt[1] ? q_head.fz_p : q_head.fz_m;
    aj     = eebe_pkg::vec_elem(cfg.tangent, j_cnt);
  end

  // dof and component counters, one result per cycle while a point waits
  always_ff @(posedge clk) begin
    if (rst) begin
      k_cnt <= '0;
      j_cnt <= '0;
    end else if (q_valid) begin
      if (j_cnt == J_LAST) begin
        j_cnt <= '0;
        k_cnt <= end_pt ? '0 : k_cnt + 1'b1;
      end else begin
        j_cnt <= j_cnt + 1'b1;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid     <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      s0_valid     <= q_valid;
      s1_valid     <= s0_valid;
      s2_valid     <= s1_valid;
      s3_valid     <= s2_valid;
      result_valid <= s3_valid;
    end
  end

  // stage 0: per-dof weights, signed tangent and curl operands
  always_ff @(posedge clk) begin
    s0_k     <= k_cnt;
    s0_j     <= j_cnt;
    s0_last  <= end_pt;
    s0_neg   <= cfg.signs[k_cnt];
    s0_fe    <= fe_sel;
    s0_fz    <= fz_sel;
    s0_deta  <= k_cnt[0] ? fz_sel : -fz_sel;
    s0_dzeta <= k_cnt[1] ? fe_sel : -fe_sel;
    s0_saj   <= cfg.signs[k_cnt] ? -AW'(aj) : AW'(aj);
    s0_pj    <= eebe_pkg::vec_elem(cfg.curl_eta, j_cnt);
    s0_qj    <= eebe_pkg::vec_elem(cfg.curl_zeta, j_cnt);
  end

  // stage 1: weight product, curl products, gradient products per direction
  always_ff @(posedge clk) begin
    s1_k    <= s0_k;
    s1_j    <= s0_j;
    s1_last <= s0_last;
    s1_neg  <= s0_neg;
    s1_saj  <= s0_saj;
    s1_fnum <= FW'(s0_fe) * FW'(s0_fz);
    s1_cp   <= PW'(s0_deta) * PW'(s0_pj);
    s1_cq   <= PW'(s0_dzeta) * PW'(s0_qj);
    for (int i = 0; i < eebe_pkg::COMP_COUNT; i++) begin
      s1_gb[i] <= PW'(eebe_pkg::vec_elem(cfg.binormal, eebe_pkg::COMP_W'(i))) * PW'(s0_deta);
      s1_gn[i] <= PW'(eebe_pkg::vec_elem(cfg.normal, eebe_pkg::COMP_W'(i))) * PW'(s0_dzeta);
    end
  end

  // stage 2: field product, signed curl sum, gradient sums
  always_ff @(posedge clk) begin
    s2_k     <= s1_k;
    s2_j     <= s1_j;
    s2_last  <= s1_last;
    s2_saj   <= s1_saj;
    s2_field <= XW'(s1_fnum) * XW'(s1_saj);
    s2_curl  <= s1_neg ? -(CW'(s1_cp) + CW'(s1_cq)) : (CW'(s1_cp) + CW'(s1_cq));
    for (int i = 0; i < eebe_pkg::COMP_COUNT; i++) begin
      s2_g[i] <= SW'(s1_gb[i]) + SW'(s1_gn[i]);
    end
  end

  // stage 3: gradient times signed tangent, round field and curl
  always_ff @(posedge clk) begin
    s3_k     <= s2_k;
    s3_j     <= s2_j;
    s3_last  <= s2_last;
    s3_field <= eebe_pkg::round_sat(64'(s2_field), eebe_pkg::FIELD_SHIFT);
    s3_curl  <= eebe_pkg::round_sat(64'(s2_curl), eebe_pkg::CURL_SHIFT);
    for (int i = 0; i < eebe_pkg::COMP_COUNT; i++) begin
      s3_grad[i] <= GW'(s2_g[i]) * GW'(s2_saj);
    end
  end

  // output register: round gradients
  always_ff @(posedge clk) begin
    dof_index   <= s3_k;
    component   <= s3_j;
    last        <= s3_last;
    field_value <= s3_field;
    curl_value  <= s3_curl;
    grad_x      <= eebe_pkg::round_sat(64'(s3_grad[0]), eebe_pkg::GRAD_SHIFT);
    grad_y      <= eebe_pkg::round_sat(64'(s3_grad[1]), eebe_pkg::GRAD_SHIFT);
    grad_z      <= eebe_pkg::round_sat(64'(s3_grad[2]), eebe_pkg::GRAD_SHIFT);
  end

  a_last_place: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |-> dof_index == K_LAST && component == J_LAST)
    else $error("last beat not on final dof and component");

  a_point_unbroken: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid)
    else $error("gap inside the results of one point");

  a_dof_step: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last && component == J_LAST |=>
      component == '0 && dof_index == $past(dof_index) + 1'b1)
    else $error("dof did not advance after its last component");

endmodule
